>>> rtl/core/indexed_quad_heap_decrease_key_top_defines.svh
// Assertion helpers for the heap block
`ifndef INDEXED_QUAD_HEAP_DECREASE_KEY_TOP_DEFINES_SVH
`define INDEXED_QUAD_HEAP_DECREASE_KEY_TOP_DEFINES_SVH

// property that must hold from the clock edge on, outside reset
`define IQH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the following cycle
`define IQH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/iqh_pkg.sv
package iqh_pkg;

  localparam int unsigned ID_W     = 10;
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned PRIO_W   = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 11;

  localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NOP   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DECREASED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_POPPED    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd5;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [ID_W-1:0]   node_id;
    logic [PRIO_W-1:0] priority_req;
  } in_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     out_id;
    logic [PRIO_W-1:0]   out_priority;
    logic [COUNT_W-1:0]  heap_count;
  } out_res_t;

endpackage

>>> rtl/core/iqh_ram.sv
module iqh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/indexed_quad_heap_decrease_key_top.sv
// Indexed 4-ary min-heap with decrease-key, one request at a time.
// A push reads the id's position, then climbs level by level to its place; a pop takes
// the root and sinks the last slot level by level (up to four child reads, one per cycle,
// on the slot memory port); clear resets the position of every touched id. busy stays
// high until out_valid; no receiver stall. Reset is synchronous active low; a clearing
// pass over all NODES entries of the position memory follows reset, with busy high.
module indexed_quad_heap_decrease_key_top #(
  parameter int unsigned NODES     = 1024,
  parameter int unsigned PRIO_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  iqh_pkg::in_req_t   in_req,
  output logic               out_valid,
  output iqh_pkg::out_res_t  out_res
);

  localparam int unsigned AW  = $clog2(NODES + 1);
  localparam int unsigned SD  = 1 << AW;
  localparam int unsigned IW  = $clog2(NODES);
  localparam int unsigned PW  = AW + 1;
  localparam int unsigned SW  = PRIO_BITS + IW;

  typedef enum logic [13:0] {
    S_INIT   = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_PRD    = 14'b00000000000100,
    S_PCHK   = 14'b00000000001000,
    S_UPRD   = 14'b00000000010000,
    S_UPCMP  = 14'b00000000100000,
    S_PLACE  = 14'b00000001000000,
    S_POP0   = 14'b00000010000000,
    S_POP1   = 14'b00000100000000,
    S_DNRD   = 14'b00001000000000,
    S_DNCMP  = 14'b00010000000000,
    S_DNMOV  = 14'b00100000000000,
    S_CLR    = 14'b01000000000000,
    S_DONE   = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  // slot memory: {prio, id}
  logic          s_we;
  logic [AW-1:0] s_wa, s_ra;
  logic [SW-1:0] s_wd, s_rd;
  // position memory: {popped, pos}
  logic          p_we;
  logic [IW-1:0] p_wa, p_ra;
  logic [PW-1:0] p_wd, p_rd;
  // touched list
  logic          t_we;
  logic [IW-1:0] t_wa, t_ra;
  logic [IW-1:0] t_wd, t_rd;

  iqh_ram #(.WIDTH(SW), .DEPTH(SD)) u_slot (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd)
  );
  iqh_ram #(.WIDTH(PW), .DEPTH(NODES)) u_pos (
    .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd)
  );
  iqh_ram #(.WIDTH(IW), .DEPTH(NODES)) u_touch (
    .clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd)
  );

  logic [AW-1:0]        size_r, size_nxt;
  logic [AW-1:0]        tcnt_r, tcnt_nxt;
  logic [AW-1:0]        slot_r, slot_nxt;
  logic [AW-1:0]        aux_r, aux_nxt;      // parent / child / clear index
  logic [AW-1:0]        best_r, best_nxt;
  logic [PRIO_BITS-1:0] bprio_r, bprio_nxt;
  logic [IW-1:0]        bid_r, bid_nxt;
  logic [2:0]           k_r, k_nxt;
  logic [PRIO_BITS-1:0] prio_r, prio_nxt;
  logic [IW-1:0]        id_r, id_nxt;
  logic [1:0]           sub_r, sub_nxt;
  logic                 ovalid_r, ovalid_nxt;
  iqh_pkg::out_res_t    res_r, res_nxt;

  logic [PRIO_BITS-1:0] rd_prio;
  logic [IW-1:0]        rd_id;
  logic [AW-1:0]        parent, first;
  logic [AW+1:0]        first_w;
  logic                 id_ok;

  assign rd_prio = s_rd[SW-1:IW];
  assign rd_id   = s_rd[IW-1:0];
  assign parent  = AW'(((slot_r - AW'(2)) >> 2) + AW'(1));
  assign first_w = {slot_r, 2'b00} - (AW+2)'(2);
  assign first   = first_w[AW-1:0];
  assign id_ok   = ({1'b0, in_req.node_id} < (iqh_pkg::ID_W + 1)'(NODES));

  assign busy      = (state_r != S_IDLE);
  assign out_valid = ovalid_r;
  assign out_res   = res_r;

  always_comb begin
    state_nxt  = state_r;
    size_nxt   = size_r;
    tcnt_nxt   = tcnt_r;
    slot_nxt   = slot_r;
    aux_nxt    = aux_r;
    best_nxt   = best_r;
    bprio_nxt  = bprio_r;
    bid_nxt    = bid_r;
    k_nxt      = k_r;
    prio_nxt   = prio_r;
    id_nxt     = id_r;
    sub_nxt    = sub_r;
    ovalid_nxt = 1'b0;
    res_nxt    = res_r;
    s_we = 1'b0; s_wa = slot_r; s_wd = {prio_r, id_r}; s_ra = slot_r;
    p_we = 1'b0; p_wa = id_r;   p_wd = {1'b0, slot_r}; p_ra = id_r;
    t_we = 1'b0; t_wa = tcnt_r[IW-1:0]; t_wd = id_r; t_ra = aux_r[IW-1:0];

    unique case (state_r)
      S_INIT: begin
        p_we = 1'b1;
        p_wa = aux_r[IW-1:0];
        p_wd = '0;
        aux_nxt = aux_r + AW'(1);
        if (aux_r == AW'(NODES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          id_nxt   = in_req.node_id[IW-1:0];
          prio_nxt = in_req.priority_req[PRIO_BITS-1:0];
          res_nxt  = '{status: iqh_pkg::ST_IGNORED, out_id: '0, out_priority: '0,
                       heap_count: iqh_pkg::COUNT_W'(size_r)};
          unique case (in_req.req_type)
            iqh_pkg::REQ_PUSH: begin
              if (id_ok) begin
                p_ra = in_req.node_id[IW-1:0];
                state_nxt = S_PRD;
              end else begin
                state_nxt = S_DONE;
              end
            end
            iqh_pkg::REQ_POP: begin
              if (size_r == '0) begin
                res_nxt.status = iqh_pkg::ST_EMPTY;
                state_nxt = S_DONE;
              end else begin
                s_ra = AW'(1);
                state_nxt = S_POP0;
              end
            end
            iqh_pkg::REQ_CLEAR: begin
              aux_nxt = '0;
              sub_nxt = '0;
              state_nxt = S_CLR;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_PRD: begin
        if (p_rd[AW-1:0] == '0) begin
          if (size_r < AW'(NODES)) begin
            if (!p_rd[PW-1] && tcnt_r < AW'(NODES)) begin
              t_we = 1'b1;
              tcnt_nxt = tcnt_r + AW'(1);
            end
            size_nxt = size_r + AW'(1);
            slot_nxt = size_r + AW'(1);
            res_nxt.status = iqh_pkg::ST_INSERTED;
            res_nxt.heap_count = iqh_pkg::COUNT_W'(size_r + AW'(1));
            state_nxt = S_UPRD;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          slot_nxt = p_rd[AW-1:0];
          s_ra = p_rd[AW-1:0];
          state_nxt = S_PCHK;
        end
      end
      S_PCHK: begin
        if (prio_r < rd_prio) begin
          res_nxt.status = iqh_pkg::ST_DECREASED;
          state_nxt = S_UPRD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_UPRD: begin
        if (slot_r == AW'(1)) begin
          state_nxt = S_PLACE;
        end else begin
          s_ra = parent;
          aux_nxt = parent;
          state_nxt = S_UPCMP;
        end
      end
      S_UPCMP: begin
        if (rd_prio <= prio_r) begin
          state_nxt = S_PLACE;
        end else begin
          s_we = 1'b1;
          s_wd = s_rd;
          p_we = 1'b1;
          p_wa = rd_id;
          slot_nxt = aux_r;
          state_nxt = S_UPRD;
        end
      end
      S_PLACE: begin
        s_we = 1'b1;
        p_we = 1'b1;
        state_nxt = S_DONE;
      end
      S_POP0: begin
        res_nxt.status = iqh_pkg::ST_POPPED;
        res_nxt.out_id = iqh_pkg::ID_W'(rd_id);
        res_nxt.out_priority = iqh_pkg::PRIO_W'(rd_prio);
        p_we = 1'b1;
        p_wa = rd_id;
        p_wd = {1'b1, {AW{1'b0}}};
        size_nxt = size_r - AW'(1);
        res_nxt.heap_count = iqh_pkg::COUNT_W'(size_r - AW'(1));
        s_ra = size_r;
        slot_nxt = AW'(1);
        state_nxt = (size_r == AW'(1)) ? S_DONE : S_POP1;
      end
      S_POP1: begin
        prio_nxt = rd_prio;
        id_nxt = rd_id;
        state_nxt = S_DNRD;
      end
      S_DNRD: begin
        if (first_w > (AW+2)'(size_r)) begin
          state_nxt = S_PLACE;
        end else begin
          s_ra = first;
          aux_nxt = first;
          k_nxt = 3'd0;
          state_nxt = S_DNCMP;
        end
      end
      S_DNCMP: begin
        // aux_r tracks the child whose data is arriving
        if (k_r == 3'd0 || rd_prio < bprio_r) begin
          best_nxt = aux_r;
          bprio_nxt = rd_prio;
          bid_nxt = rd_id;
        end
        if (k_r == 3'd3 || aux_r >= size_r) begin
          state_nxt = S_DNMOV;
        end else begin
          aux_nxt = aux_r + AW'(1);
          s_ra = aux_r + AW'(1);
          k_nxt = k_r + 3'd1;
        end
      end
      S_DNMOV: begin
        if (prio_r <= bprio_r) begin
          state_nxt = S_PLACE;
        end else begin
          s_we = 1'b1;
          s_wd = {bprio_r, bid_r};
          p_we = 1'b1;
          p_wa = bid_r;
          slot_nxt = best_r;
          state_nxt = S_DNRD;
        end
      end
      S_CLR: begin
        if (sub_r == 2'd0) begin
          if (aux_r >= tcnt_r) begin
            tcnt_nxt = '0;
            size_nxt = '0;
            res_nxt.status = iqh_pkg::ST_CLEARED;
            res_nxt.heap_count = '0;
            state_nxt = S_DONE;
          end else begin
            sub_nxt = 2'd1;
          end
        end else begin
          p_we = 1'b1;
          p_wa = t_rd;
          p_wd = '0;
          aux_nxt = aux_r + AW'(1);
          sub_nxt = 2'd0;
        end
      end
      S_DONE: begin
        ovalid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT;
      size_r   <= '0;
      tcnt_r   <= '0;
      aux_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      size_r   <= size_nxt;
      tcnt_r   <= tcnt_nxt;
      aux_r    <= aux_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r  <= slot_nxt;
    best_r  <= best_nxt;
    bprio_r <= bprio_nxt;
    bid_r   <= bid_nxt;
    k_r     <= k_nxt;
    prio_r  <= prio_nxt;
    id_r    <= id_nxt;
    sub_r   <= sub_nxt;
    res_r   <= res_nxt;
  end

`include "indexed_quad_heap_decrease_key_top_defines.svh"

  `IQH_ASSERT(a_size_range, size_r <= AW'(NODES), "heap size beyond capacity")
  `IQH_ASSERT(a_touch_range, tcnt_r <= AW'(NODES), "touched count beyond capacity")
  `IQH_ASSERT_NEXT(a_done_strobe, state_r == S_DONE, out_valid && !busy, "result not issued")
  `IQH_ASSERT(a_strobe_idle, !out_valid || state_r == S_IDLE, "result while busy")

endmodule

>>> tb/indexed_quad_heap_decrease_key_top_tb.sv
module indexed_quad_heap_decrease_key_top_tb;

  localparam int unsigned NODES = 1024;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  iqh_pkg::in_req_t  in_req;
  logic              out_valid;
  iqh_pkg::out_res_t out_res;

  indexed_quad_heap_decrease_key_top #(.NODES(NODES), .PRIO_BITS(32)) u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // heap shadow
  logic [31:0] hp_prio [1:NODES];
  logic [9:0]  hp_node [1:NODES];
  int unsigned pos_of [NODES];
  bit          was_popped [NODES];
  logic [9:0]  touched [NODES];
  int unsigned touched_n;
  int unsigned heap_n;

  iqh_pkg::in_req_t  req_q [$];
  iqh_pkg::out_res_t expected_q [$];
  int       req_left;
  int       mismatches;
  bit       no_idle;
  bit       hold_drain;
  int       gap_left;

  function automatic void put_slot(int unsigned s, logic [31:0] p, logic [9:0] id);
    hp_prio[s] = p;
    hp_node[s] = id;
    pos_of[id] = s;
  endfunction

  function automatic void climb(int unsigned s);
    logic [31:0] p;
    logic [9:0]  id;
    int unsigned up;
    p  = hp_prio[s];
    id = hp_node[s];
    while (s > 1) begin
      up = (s - 2) / 4 + 1;
      if (hp_prio[up] <= p) break;
      put_slot(s, hp_prio[up], hp_node[up]);
      s = up;
    end
    put_slot(s, p, id);
  endfunction

  function automatic void sink(int unsigned s);
    logic [31:0] p, bp;
    logic [9:0]  id;
    int unsigned first, best;
    p  = hp_prio[s];
    id = hp_node[s];
    forever begin
      first = s * 4 - 2;
      if (first > heap_n) break;
      best = first;
      bp   = hp_prio[first];
      for (int k = 1; k < 4; k++)
        if (first + k <= heap_n && hp_prio[first + k] < bp) begin
          best = first + k;
          bp   = hp_prio[best];
        end
      if (p <= bp) break;
      put_slot(s, bp, hp_node[best]);
      s = best;
    end
    put_slot(s, p, id);
  endfunction

  function automatic iqh_pkg::out_res_t heap_apply(iqh_pkg::in_req_t r);
    iqh_pkg::out_res_t res;
    int unsigned       p;
    res = '0;
    res.status = iqh_pkg::ST_IGNORED;
    if (r.req_type == iqh_pkg::REQ_PUSH) begin
      p = pos_of[r.node_id];
      if (p == 0) begin
        if (heap_n < NODES) begin
          if (!was_popped[r.node_id] && touched_n < NODES) begin
            touched[touched_n] = r.node_id;
            touched_n++;
          end
          heap_n++;
          put_slot(heap_n, r.priority_req, r.node_id);
          climb(heap_n);
          res.status = iqh_pkg::ST_INSERTED;
        end
      end else if (r.priority_req < hp_prio[p]) begin
        put_slot(p, r.priority_req, r.node_id);
        climb(p);
        res.status = iqh_pkg::ST_DECREASED;
      end
    end else if (r.req_type == iqh_pkg::REQ_POP) begin
      if (heap_n == 0) begin
        res.status = iqh_pkg::ST_EMPTY;
      end else begin
        res.out_priority = hp_prio[1];
        res.out_id = hp_node[1];
        pos_of[hp_node[1]] = 0;
        was_popped[hp_node[1]] = 1'b1;
        if (heap_n == 1) begin
          heap_n = 0;
        end else begin
          put_slot(1, hp_prio[heap_n], hp_node[heap_n]);
          heap_n--;
          sink(1);
        end
        res.status = iqh_pkg::ST_POPPED;
      end
    end else if (r.req_type == iqh_pkg::REQ_CLEAR) begin
      for (int k = 0; k < touched_n; k++) begin
        pos_of[touched[k]] = 0;
        was_popped[touched[k]] = 1'b0;
      end
      touched_n = 0;
      heap_n = 0;
      res.status = iqh_pkg::ST_CLEARED;
    end
    res.heap_count = heap_n[10:0];
    return res;
  endfunction

  function automatic iqh_pkg::in_req_t mk(logic [1:0] t, logic [9:0] id, logic [31:0] p);
    iqh_pkg::in_req_t r;
    r.req_type = t;
    r.node_id = id;
    r.priority_req = p;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_req <= '0;
      gap_left <= 0;
    end else if (start && !busy) begin
      expected_q.push_back(heap_apply(in_req));
      req_left <= req_left - 1;
      if (!no_idle && $urandom_range(0, 5) == 0) begin
        start <= 1'b0;
        gap_left <= $urandom_range(1, 12);
      end else if (req_q.size() != 0) begin
        in_req <= req_q.pop_front();
      end else begin
        start <= 1'b0;
      end
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (req_q.size() != 0 && !(hold_drain && expected_q.size() != 0)) begin
        start <= 1'b1;
        in_req <= req_q.pop_front();
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_res);
      end else begin
        iqh_pkg::out_res_t e;
        e = expected_q.pop_front();
        if (out_res !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch exp %p got %p", e, out_res);
        end
      end
    end
  end

  function automatic void add_random(int n);
    int unsigned kind;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 55)
        req_q.push_back(mk(iqh_pkg::REQ_PUSH, 10'($urandom_range(0, 63)),
          ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 200))));
      else if (kind < 60)
        req_q.push_back(mk(iqh_pkg::REQ_PUSH, 10'($urandom), $urandom));
      else if (kind < 94)
        req_q.push_back(mk(iqh_pkg::REQ_POP, 10'($urandom), $urandom));
      else if (kind < 96)
        req_q.push_back(mk(iqh_pkg::REQ_CLEAR, 10'($urandom), $urandom));
      else
        req_q.push_back(mk(iqh_pkg::REQ_NOP, 10'($urandom), $urandom));
    end
  endfunction

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    mismatches = 0;
    no_idle = 1'b0;
    hold_drain = 1'b0;
    heap_n = 0;
    touched_n = 0;
    for (int i = 0; i < NODES; i++) begin
      pos_of[i] = 0;
      was_popped[i] = 1'b0;
    end
    // directed
    req_q.push_back(mk(iqh_pkg::REQ_POP, 10'h3ff, 32'hffff_ffff));
    req_q.push_back(mk(iqh_pkg::REQ_PUSH, 10'd0, 32'hffff_ffff));
    req_q.push_back(mk(iqh_pkg::REQ_PUSH, 10'h3ff, 32'd0));
    req_q.push_back(mk(iqh_pkg::REQ_PUSH, 10'd5, 32'd100));
    req_q.push_back(mk(iqh_pkg::REQ_PUSH, 10'd6, 32'd100));
    req_q.push_back(mk(iqh_pkg::REQ_PUSH, 10'd7, 32'd50));
    req_q.push_back(mk(iqh_pkg::REQ_PUSH, 10'd5, 32'd100));
    req_q.push_back(mk(iqh_pkg::REQ_PUSH, 10'd5, 32'd200));
    req_q.push_back(mk(iqh_pkg::REQ_PUSH, 10'd6, 32'd10));
    req_q.push_back(mk(iqh_pkg::REQ_PUSH, 10'd0, 32'd1));
    req_q.push_back(mk(iqh_pkg::REQ_NOP, 10'h2aa, 32'h5555_5555));
    for (int i = 0; i < 4; i++) req_q.push_back(mk(iqh_pkg::REQ_POP, 10'd0, 32'd0));
    req_q.push_back(mk(iqh_pkg::REQ_PUSH, 10'h3ff, 32'd7));
    req_q.push_back(mk(iqh_pkg::REQ_PUSH, 10'd6, 32'd3));
    req_q.push_back(mk(iqh_pkg::REQ_CLEAR, 10'h155, 32'haaaa_aaaa));
    req_q.push_back(mk(iqh_pkg::REQ_PUSH, 10'd6, 32'd9));
    for (int i = 0; i < 3; i++) req_q.push_back(mk(iqh_pkg::REQ_POP, 10'd0, 32'd0));
    req_left = req_q.size() + 1200;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    add_random(500);
    wait (req_q.size() == 0);
    hold_drain = 1'b1;
    add_random(400);
    wait (req_q.size() < 300);
    hold_drain = 1'b0;
    wait (req_q.size() == 0);
    no_idle = 1'b1;
    add_random(300);
    wait (req_left <= 0 && expected_q.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
